### rtl/dtd_pkg.sv
package dtd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LEN_W   = 9;

  localparam logic [YEAR_W-1:0] EPOCH_RESET = 14'd2000;

  // Epoch reduction modulo 400: restoring steps that subtract 400 << i.
  localparam int unsigned MOD_STEPS = 6;
  localparam int unsigned STEP_W    = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST = 3'(MOD_STEPS - 1);

  typedef logic [YEAR_W-1:0] mod_tab_t [MOD_STEPS];
  localparam mod_tab_t MOD_SUB = '{14'd400, 14'd800, 14'd1600, 14'd3200, 14'd6400, 14'd12800};

  localparam logic [YEAR_W-1:0] CYCLE_LAST = 14'd399;

  localparam logic [LEN_W-1:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [LEN_W-1:0] DAYS_COMMON_YEAR = 9'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_YEAR,
    ST_MONTH,
    ST_HOLD
  } dtd_state_t;

  typedef struct packed {
    logic              load;
    logic              mod_en;
    logic [STEP_W-1:0] mod_idx;
    logic              year_en;
    logic              month_en;
    logic              out_load;
  } dtd_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dtd_stat_t;

  // Leap rule from the year modulo 400.
  function automatic logic is_leap(input logic [LEN_W-1:0] r400);
    return (r400[1:0] == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/dtd_ctrl.sv
module dtd_ctrl
  import dtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dtd_stat_t stat,
  output dtd_cmd_t  cmd
);

  dtd_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mod_idx = step_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = STEP_FIRST;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_en = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_YEAR;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      ST_YEAR: begin
        cmd.year_en = 1'b1;
        if (stat.year_done) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.month_en = 1'b1;
        if (stat.month_done) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

endmodule

### rtl/dtd_dp.sv
module dtd_dp
  import dtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [YEAR_W-1:0]  cfg_base_year,
  input  logic [COUNT_W-1:0] in_day_count,
  input  dtd_cmd_t           cmd,
  output dtd_stat_t          stat,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day_of_month
);

  logic [YEAR_W-1:0]  epoch_r;
  logic [COUNT_W-1:0] rest_r;
  logic [YEAR_W-1:0]  year_r;
  logic [YEAR_W-1:0]  mod_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [DAY_W-1:0]   out_day_r;

  logic               leap;
  logic [LEN_W-1:0]   year_len;
  logic [DAY_W-1:0]   mlen;

  // mod_r holds the year modulo 400 once the reduction steps are done.
  assign leap     = is_leap(mod_r[LEN_W-1:0]);
  assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign mlen     = month_len(month_r, leap);

  assign stat.year_done  = rest_r < COUNT_W'(year_len);
  assign stat.month_done = (month_r == MONTH_DEC) || (rest_r < COUNT_W'(mlen));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      epoch_r <= cfg_base_year;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r  <= in_day_count;
      year_r  <= epoch_r;
      mod_r   <= epoch_r;
      month_r <= MONTH_JAN;
    end
    if (cmd.mod_en && (mod_r >= MOD_SUB[cmd.mod_idx])) begin
      mod_r <= mod_r - MOD_SUB[cmd.mod_idx];
    end
    if (cmd.year_en && !stat.year_done) begin
      rest_r <= rest_r - COUNT_W'(year_len);
      year_r <= year_r + 14'd1;
      mod_r  <= (mod_r == CYCLE_LAST) ? '0 : mod_r + 14'd1;
    end
    if (cmd.month_en && !stat.month_done) begin
      rest_r  <= rest_r - COUNT_W'(mlen);
      month_r <= month_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_year_r  <= year_r;
      out_month_r <= month_r;
      out_day_r   <= rest_r[DAY_W-1:0] + 5'd1;
    end
  end

  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_day_r;

endmodule

### rtl/day_number_to_date.sv
// Time from the accepting edge to out_valid grows with Y + M, where Y is the number of
// whole years removed (at most 179) and M the number of whole months (at most 11).
// Throughput: one word per conversion; the next word is taken in the cycle after the result
// is loaded into the output register. The time per word is set mostly by the
// one-year-per-cycle subtract loop, plus any wait for a stalled result word.
// Reset (rst_n low, synchronous) idles the controller, drops out_valid, sets base year 2000.
module day_number_to_date
  import dtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write channel: the epoch year.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [YEAR_W-1:0]  cfg_base_year,
  // Input channel: one day count per word.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_day_count,
  // Result channel: one date per word.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day_of_month
);

  // The controller sequences the conversion: it first reduces the epoch year modulo 400
  // in six restoring subtract steps so that the leap rule needs only small compares,
  // then removes whole years one per cycle, then whole months one per cycle. The
  // datapath holds the running remainder, the year, its value modulo 400 and the month.
  // A finished date waits in the datapath until the output register is free, so a
  // consumer that stalls never loses or repeats a word.

  dtd_cmd_t  cmd;
  dtd_stat_t stat;

  // Epoch register always writable; writes must only be made while idle (not enforced).
  assign cfg_ready = 1'b1;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_base_year    (cfg_base_year),
    .in_day_count     (in_day_count),
    .cmd              (cmd),
    .stat             (stat),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month)
  );

endmodule

### rtl/dtd_chk.sv
module dtd_chk
  import dtd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  out_year,
  input logic [MONTH_W-1:0] out_month,
  input logic [DAY_W-1:0]   out_day_of_month
);

  // A stalled result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day_of_month))
    else $error("result word changed while stalled");

  // One conversion at a time: after an accept the input side closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during a conversion");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= MONTH_JAN && out_month <= MONTH_DEC)
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_of_month != 5'd0)
    else $error("day of month is zero");

endmodule

bind day_number_to_date dtd_chk u_dtd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month)
);
